// ----- rtl/gfp_frame_delineation_descrambler_assert.svh -----
// Assertion macros shared by the frame delineation and descrambler modules.
`ifndef GFP_FRAME_DELINEATION_DESCRAMBLER_ASSERT_SVH
`define GFP_FRAME_DELINEATION_DESCRAMBLER_ASSERT_SVH

// Checks that a condition implies a consequence in the same cycle.
`define GFPD_ASSERT_IMP(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error(msg);

// Checks that a condition implies a consequence in the next cycle.
`define GFPD_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// ----- rtl/gfpd_pkg.sv -----
// Shared types and constants for the frame delineation and descrambler block.
package gfpd_pkg;

	localparam int unsigned CfgIdxW = 2;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_HEADER_MASK   = 2'd0,
		CFG_PAYLOAD_SKIP  = 2'd1,
		CFG_DESCRAMBLE_EN = 2'd2
	} cfg_idx_t;

	localparam logic [31:0] HeaderMaskReset = 32'hB6AB_31E0;
	localparam logic [3:0]  PayloadSkipReset = 4'd4;
	localparam logic [3:0]  PayloadIndexMax = 4'd15;

	// Item passed from the front part to the back part.
	typedef struct packed {
		logic        is_payload;
		logic [15:0] value;
		logic        last;
	} gfpd_item_t;

	function automatic logic [7:0] flip8(input logic [7:0] b);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) begin
			r[i] = b[7-i];
		end
		return r;
	endfunction

endpackage

// ----- rtl/gfpd_front.sv -----
// Front part: hunts for the idle header, aligns bytes and splits headers from payload.
module gfpd_front import gfpd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [7:0]       data_byte,
	input  logic [31:0]      header_mask,
	input  logic [3:0]       payload_skip,
	output logic             out_valid,
	output gfpd_item_t       out_item,
	output logic             out_aligned_valid,
	output logic [7:0]       out_aligned
);

	logic        locked_q;
	logic [31:0] hunt_window_q;
	logic [2:0]  bit_offset_q;
	logic [7:0]  carry_bits_q;
	logic [1:0]  header_count_q;
	logic [23:0] header_word_q;
	logic [15:0] payload_left_q;
	logic [3:0]  payload_index_q;

	logic [7:0]  r;
	logic [7:0]  aligned;
	logic [7:0]  carry_nxt;
	logic [31:0] win [8];
	logic [7:0]  hit;
	logic        found;
	logic [2:0]  found_k;
	logic [15:0] len;
	logic [15:0] left_dec;

	always_comb begin
		r = flip8(data_byte);
		// Window after each of the eight bits is shifted in, earliest bit first.
		win[0] = {hunt_window_q[30:0], data_byte[0]};
		for (int k = 1; k < 8; k++) begin
			win[k] = {win[k-1][30:0], data_byte[k]};
		end
		for (int k = 0; k < 8; k++) begin
			hit[k] = (win[k] == header_mask);
		end
		found = 1'b0;
		found_k = '0;
		for (int k = 7; k >= 0; k--) begin
			if (hit[k]) begin
				found = 1'b1;
				found_k = 3'(k);
			end
		end
		aligned = r;
		carry_nxt = '0;
		if (bit_offset_q != 3'd0) begin
			aligned = 8'(({8'd0, carry_bits_q} << (4'd8 - {1'b0, bit_offset_q}))
				| ({8'd0, r} >> bit_offset_q));
			carry_nxt = r & 8'((9'd1 << bit_offset_q) - 9'd1);
		end
		len = header_word_q[23:8] ^ header_mask[31:16];
		left_dec = payload_left_q - 16'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			locked_q <= 1'b0;
			hunt_window_q <= '0;
			bit_offset_q <= '0;
			carry_bits_q <= '0;
			header_count_q <= '0;
			header_word_q <= '0;
			payload_left_q <= '0;
			payload_index_q <= '0;
			out_valid <= 1'b0;
			out_aligned_valid <= 1'b0;
		end else begin
			out_valid <= 1'b0;
			out_aligned_valid <= 1'b0;
			if (in_valid) begin
				if (!locked_q) begin
					if (found) begin
						locked_q <= 1'b1;
						bit_offset_q <= 3'd7 - found_k;
						carry_bits_q <= r & 8'((9'd1 << (3'd7 - found_k)) - 9'd1);
						header_count_q <= '0;
						header_word_q <= '0;
						payload_left_q <= '0;
						payload_index_q <= '0;
					end else begin
						hunt_window_q <= win[7];
					end
				end else begin
					carry_bits_q <= carry_nxt;
					if (payload_left_q == 16'd0) begin
						if (header_count_q != 2'd3) begin
							header_word_q <= {header_word_q[15:0], aligned};
							header_count_q <= header_count_q + 2'd1;
						end else begin
							header_word_q <= '0;
							header_count_q <= '0;
							if (len != 16'd0) begin
								payload_left_q <= len;
								payload_index_q <= '0;
								out_valid <= 1'b1;
								out_item.is_payload <= 1'b0;
								out_item.value <= (len > {12'd0, payload_skip})
									? len - {12'd0, payload_skip} : 16'd0;
								out_item.last <= 1'b0;
							end
						end
					end else begin
						payload_left_q <= left_dec;
						if (payload_index_q != PayloadIndexMax) begin
							payload_index_q <= payload_index_q + 4'd1;
						end
						// Every payload byte feeds the descrambler; only some are emitted.
						out_aligned_valid <= 1'b1;
						out_aligned <= aligned;
						out_valid <= (payload_index_q >= payload_skip);
						out_item.is_payload <= 1'b1;
						out_item.value <= '0;
						out_item.last <= (left_dec == 16'd0);
					end
				end
			end
		end
	end

	`include "gfp_frame_delineation_descrambler_assert.svh"

	`GFPD_ASSERT_NEXT(a_lock_sticky, clk, arst_n, locked_q, locked_q, "lock was lost")
	`GFPD_ASSERT_NEXT(a_no_out_hunting, clk, arst_n, !locked_q, !out_valid,
		"result produced while hunting")
	`GFPD_ASSERT_IMP(a_out_has_aligned, clk, arst_n, out_valid && out_item.is_payload,
		out_aligned_valid, "payload result without descrambler byte")

endmodule

// ----- rtl/gfpd_back.sv -----
// Back part: descrambles payload bytes and queues results for the consumer.
module gfpd_back import gfpd_pkg::*; #(
	parameter int unsigned SCRAMBLER_LAG = 43,
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             descramble_enable,
	input  logic             in_valid,
	input  gfpd_item_t       in_item,
	input  logic             in_aligned_valid,
	input  logic [7:0]       in_aligned,
	output logic             almost_full,
	output logic             empty,
	input  logic             pop,
	output logic             kind,
	output logic [15:0]      value,
	output logic             frame_last
);

	localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
	localparam int unsigned HistW = SCRAMBLER_LAG + 8;

	logic [SCRAMBLER_LAG-1:0] history_q;
	logic [HistW-1:0]         ext;
	logic [7:0]               desc;
	gfpd_item_t               entry;
	gfpd_item_t               queue_q [QUEUE_DEPTH];
	logic [PtrW-1:0]          wr_ptr_q;
	logic [PtrW-1:0]          rd_ptr_q;
	logic [PtrW:0]            count_q;
	logic                     do_push;
	logic                     do_pop;

	always_comb begin
		ext = {history_q, in_aligned};
		// Output bit j uses the bit SCRAMBLER_LAG positions earlier in the stream.
		for (int j = 0; j < 8; j++) begin
			desc[j] = in_aligned[j] ^ (descramble_enable & ext[j + SCRAMBLER_LAG]);
		end
		entry = in_item;
		if (in_item.is_payload) begin
			entry.value = {8'd0, desc};
		end
		do_push = in_valid;
		do_pop = pop && (count_q != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			history_q <= '0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (in_aligned_valid) begin
				history_q <= ext[SCRAMBLER_LAG-1:0];
			end
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (PtrW+1)'(do_push) - (PtrW+1)'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			queue_q[wr_ptr_q] <= entry;
		end
	end

	// Free entries are kept for the item that may already be inside the front part.
	assign almost_full = (count_q >= (PtrW+1)'(QUEUE_DEPTH - 2));
	assign empty = (count_q == '0);
	assign kind = queue_q[rd_ptr_q].is_payload;
	assign value = queue_q[rd_ptr_q].value;
	assign frame_last = queue_q[rd_ptr_q].last;

	`include "gfp_frame_delineation_descrambler_assert.svh"

	`GFPD_ASSERT_IMP(a_no_overflow, clk, arst_n, do_push && !do_pop,
		count_q < (PtrW+1)'(QUEUE_DEPTH), "result queue overflow")
	`GFPD_ASSERT_IMP(a_record_not_last, clk, arst_n, !empty && !kind, !frame_last,
		"length record flagged as last")

endmodule

// ----- rtl/gfp_frame_delineation_descrambler.sv -----
// Top level of the frame delineation and payload descrambler.
// One byte is taken per clock while full is low; any result it yields reaches the result ports
// through the front register stage and a four-entry queue, and full rises when that queue holds
// two or more results, which leaves room for the one byte that may be in flight in the front
// register stage. Hunting compares all eight bit offsets of a byte at once; the x^43+1
// descrambler handles a whole byte per cycle.
module gfp_frame_delineation_descrambler import gfpd_pkg::*; #(
	parameter int unsigned SCRAMBLER_LAG = 43
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	output logic        empty,
	input  logic        pop,
	output logic        kind,
	output logic [15:0] value,
	output logic        frame_last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	logic [31:0] header_mask_q;
	logic [3:0]  payload_skip_q;
	logic        descramble_en_q;
	logic        front_valid;
	gfpd_item_t  front_item;
	logic        aligned_valid;
	logic [7:0]  aligned;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_mask_q <= HeaderMaskReset;
			payload_skip_q <= PayloadSkipReset;
			descramble_en_q <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_HEADER_MASK:   header_mask_q <= cfg_data;
				CFG_PAYLOAD_SKIP:  payload_skip_q <= cfg_data[3:0];
				CFG_DESCRAMBLE_EN: descramble_en_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	gfpd_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(push && !full),
		.data_byte(data_byte),
		.header_mask(header_mask_q),
		.payload_skip(payload_skip_q),
		.out_valid(front_valid),
		.out_item(front_item),
		.out_aligned_valid(aligned_valid),
		.out_aligned(aligned)
	);

	gfpd_back #(
		.SCRAMBLER_LAG(SCRAMBLER_LAG),
		.QUEUE_DEPTH(4)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.descramble_enable(descramble_en_q),
		.in_valid(front_valid),
		.in_item(front_item),
		.in_aligned_valid(aligned_valid),
		.in_aligned(aligned),
		.almost_full(full),
		.empty(empty),
		.pop(pop),
		.kind(kind),
		.value(value),
		.frame_last(frame_last)
	);

endmodule
